>>> src/brm_pkg.sv
// ----------------------------------------------------------------------------
// brm_pkg: shared types and constants of the bucket repeat marker
// Field widths, item modes, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package brm_pkg;

  localparam int N_CHUNK      = 5;
  localparam int CHUNK_BASES  = 20;
  localparam int BASE_W       = 3;
  localparam int STORED_BASES = N_CHUNK * CHUNK_BASES;
  localparam int CHUNK_W      = CHUNK_BASES * BASE_W;
  localparam int ROW_W        = N_CHUNK * CHUNK_W;
  localparam int LEN_W        = 7;
  localparam int POS_W        = 32;
  localparam int CIDX_W       = 3;
  localparam int MODE_W       = 2;
  localparam int CFG_ADDR_W   = 2;

  localparam logic [LEN_W-1:0] SHORT_LEN_RST = 7'd90;
  localparam logic [LEN_W-1:0] LONG_LEN_RST  = 7'd100;

  localparam logic [CFG_ADDR_W-1:0] REG_SHORT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LONG  = 2'd1;

  localparam logic [MODE_W-1:0] MODE_HDR   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CHUNK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GO    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RSVD  = 2'd3;  // ignored

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDA,
    S_LDA,
    S_SCAN,
    S_OUT
  } state_t;

  // write controls from the loader to the entry store
  typedef struct packed {
    logic              hdr_we;
    logic              chk_we;
    logic [CIDX_W-1:0] chk_idx;
  } wr_ctl_t;

endpackage

>>> src/brm_if.sv
// ----------------------------------------------------------------------------
// brm_if: valid/ready channels of the bucket repeat marker
// Input word carries headers, chunks and go; output word carries one result.
// ----------------------------------------------------------------------------
interface brm_in_if;
  logic                              valid;
  logic                              ready;
  logic [brm_pkg::MODE_W-1:0]        mode;
  logic [brm_pkg::POS_W-1:0]         in_position;
  logic                              in_strand;
  logic [brm_pkg::LEN_W-1:0]         room;
  logic [brm_pkg::CIDX_W-1:0]        chunk_index;
  logic [brm_pkg::CHUNK_W-1:0]       chunk;

  modport source (output valid, mode, in_position, in_strand, room, chunk_index, chunk,
                  input ready);
  modport sink   (input valid, mode, in_position, in_strand, room, chunk_index, chunk,
                  output ready);
endinterface

interface brm_out_if;
  logic                        valid;
  logic                        ready;
  logic [brm_pkg::POS_W-1:0]   out_position;
  logic                        out_strand;
  logic                        mark_short;
  logic                        mark_long;
  logic                        overflow;
  logic                        last;

  modport source (output valid, out_position, out_strand, mark_short, mark_long,
                  overflow, last, input ready);
  modport sink   (input valid, out_position, out_strand, mark_short, mark_long,
                  overflow, last, output ready);
endinterface

>>> src/brm_store.sv
// ----------------------------------------------------------------------------
// brm_store: entry memories of one bucket
// Position, strand, room and five chunk memories, one write and one
// registered read per cycle. A header zeroes its row in all chunk memories.
// ----------------------------------------------------------------------------
module brm_store #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  brm_pkg::wr_ctl_t              wr,
  input  logic [$clog2(DEPTH)-1:0]      wr_row,
  input  logic [brm_pkg::POS_W-1:0]     wr_pos,
  input  logic                          wr_strand,
  input  logic [brm_pkg::LEN_W-1:0]     wr_room,
  input  logic [brm_pkg::CHUNK_W-1:0]   wr_chunk,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [brm_pkg::POS_W-1:0]     rd_pos,
  output logic                          rd_strand,
  output logic [brm_pkg::LEN_W-1:0]     rd_room,
  output logic [brm_pkg::ROW_W-1:0]     rd_row
);

  logic [brm_pkg::POS_W-1:0]   pos_mem    [DEPTH];
  logic                        strand_mem [DEPTH];
  logic [brm_pkg::LEN_W-1:0]   room_mem   [DEPTH];

  // header fields
  always_ff @(posedge clk) begin
    if (wr.hdr_we) begin
      pos_mem[wr_row]    <= wr_pos;
      strand_mem[wr_row] <= wr_strand;
      room_mem[wr_row]   <= wr_room;
    end
    rd_pos    <= pos_mem[rd_addr];
    rd_strand <= strand_mem[rd_addr];
    rd_room   <= room_mem[rd_addr];
  end

  // one memory per chunk slot; unsent chunks stay zero from the header
  for (genvar c = 0; c < brm_pkg::N_CHUNK; c++) begin : g_chunk
    logic [brm_pkg::CHUNK_W-1:0] chunk_mem [DEPTH];
    logic [brm_pkg::CHUNK_W-1:0] rd_chunk_r;

    always_ff @(posedge clk) begin
      if (wr.hdr_we) begin
        chunk_mem[wr_row] <= '0;
      end else if (wr.chk_we && wr.chk_idx == brm_pkg::CIDX_W'(c)) begin
        chunk_mem[wr_row] <= wr_chunk;
      end
      rd_chunk_r <= chunk_mem[rd_addr];
    end

    assign rd_row[c*brm_pkg::CHUNK_W +: brm_pkg::CHUNK_W] = rd_chunk_r;
  end

endmodule

>>> src/bucket_repeat_marker_top.sv
// ----------------------------------------------------------------------------
// bucket_repeat_marker_top: repeat marking for one hash bucket
// Loads entries into memory, then on go compares every entry with all others.
// ----------------------------------------------------------------------------
// Load words (header, chunk) are accepted back to back, one per cycle, while idle.
// A go word with n entries visits, per entry, S_RDA (one read to fetch it),
//   S_LDA (hold it), S_SCAN (one read of each entry through the single store
//   read port) and S_OUT (hand over its result word; output stalls hold here).
// Reset (rst_n low, synchronous) empties the bucket and loads short_len 90,
//   long_len 100. A header zeroes its own chunks, so no clearing pass.
module bucket_repeat_marker_top #(
  parameter int BUCKET_DEPTH = 64,
  parameter int MAX_COMPARE  = 100
) (
  input  logic                              clk,
  input  logic                              rst_n,
  brm_in_if.sink                            in_ch,
  brm_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [brm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [brm_pkg::LEN_W-1:0]         cfg_wdata
);

  localparam int AW  = $clog2(BUCKET_DEPTH);
  localparam int CW  = $clog2(BUCKET_DEPTH + 1);
  localparam int LIM = (MAX_COMPARE < brm_pkg::STORED_BASES) ? MAX_COMPARE
                                                           : brm_pkg::STORED_BASES;
  localparam int NB  = brm_pkg::STORED_BASES;
  localparam int BW  = brm_pkg::BASE_W;

  brm_pkg::state_t state_r, state_nxt;

  logic [brm_pkg::LEN_W-1:0] short_len_r, long_len_r;
  logic [brm_pkg::LEN_W-1:0] ls_r, ll_r, ls_c, ll_c;
  logic [NB-1:0]             mask_s_r, mask_l_r, mask_s_c, mask_l_c;
  logic [CW-1:0]             cnt_r;
  logic                      ovf_r;
  logic [AW-1:0]             i_r, j_r;
  logic                      hit_s_r, hit_l_r;

  logic [brm_pkg::POS_W-1:0] a_pos_r;
  logic                      a_strand_r;
  logic                      a_ok_s_r, a_ok_l_r;
  logic [brm_pkg::ROW_W-1:0] a_row_r;

  brm_pkg::wr_ctl_t          wr;
  logic [AW-1:0]             wr_row, rd_addr;
  logic [brm_pkg::POS_W-1:0] rd_pos;
  logic                      rd_strand;
  logic [brm_pkg::LEN_W-1:0] rd_room;
  logic [brm_pkg::ROW_W-1:0] rd_row;

  logic                      in_acc, out_acc, is_last, j_last;
  logic                      full, hdr_ok, chk_ok;
  logic [NB-1:0]             diff;
  logic                      cmp_s, cmp_l;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign full    = (cnt_r == CW'(BUCKET_DEPTH));
  assign is_last = (CW'(i_r) == CW'(cnt_r - CW'(1)));
  assign j_last  = (CW'(j_r) == CW'(cnt_r - CW'(1)));

  // load-side write decode
  assign hdr_ok = in_acc && in_ch.mode == brm_pkg::MODE_HDR && !full;
  assign chk_ok = in_acc && in_ch.mode == brm_pkg::MODE_CHUNK && !ovf_r &&
                  cnt_r != '0 && in_ch.chunk_index < brm_pkg::CIDX_W'(brm_pkg::N_CHUNK);
  assign wr.hdr_we  = hdr_ok;
  assign wr.chk_we  = chk_ok;
  assign wr.chk_idx = in_ch.chunk_index;
  assign wr_row     = hdr_ok ? cnt_r[AW-1:0] : AW'(cnt_r - CW'(1));

  brm_store #(.DEPTH(BUCKET_DEPTH)) u_store (
    .clk       (clk),
    .wr        (wr),
    .wr_row    (wr_row),
    .wr_pos    (in_ch.in_position),
    .wr_strand (in_ch.in_strand),
    .wr_room   (in_ch.room),
    .wr_chunk  (in_ch.chunk),
    .rd_addr   (rd_addr),
    .rd_pos    (rd_pos),
    .rd_strand (rd_strand),
    .rd_room   (rd_room),
    .rd_row    (rd_row)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_len_r <= brm_pkg::SHORT_LEN_RST;
      long_len_r  <= brm_pkg::LONG_LEN_RST;
    end else if (cfg_we) begin
      if (cfg_addr == brm_pkg::REG_SHORT) short_len_r <= cfg_wdata;
      if (cfg_addr == brm_pkg::REG_LONG)  long_len_r  <= cfg_wdata;
    end
  end

  // clamped lengths and per-base masks, captured at go
  always_comb begin
    ls_c = (int'(short_len_r) > LIM) ? brm_pkg::LEN_W'(LIM) : short_len_r;
    ll_c = (int'(long_len_r)  > LIM) ? brm_pkg::LEN_W'(LIM) : long_len_r;
    for (int b = 0; b < NB; b++) begin
      mask_s_c[b] = (brm_pkg::LEN_W'(b) < ls_c);
      mask_l_c[b] = (brm_pkg::LEN_W'(b) < ll_c);
    end
  end

  // per-base mismatch between the held entry and the scanned one
  always_comb begin
    for (int b = 0; b < NB; b++) begin
      diff[b] = |(a_row_r[b*BW +: BW] ^ rd_row[b*BW +: BW]);
    end
  end

  assign cmp_s = a_ok_s_r && (j_r != i_r) && (rd_room >= ls_r) && !(|(diff & mask_s_r));
  assign cmp_l = a_ok_l_r && (j_r != i_r) && (rd_room >= ll_r) && !(|(diff & mask_l_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      brm_pkg::S_IDLE: begin
        if (in_acc && in_ch.mode == brm_pkg::MODE_GO && cnt_r != '0)
          state_nxt = brm_pkg::S_RDA;
      end
      brm_pkg::S_RDA:  state_nxt = brm_pkg::S_LDA;
      brm_pkg::S_LDA:  state_nxt = brm_pkg::S_SCAN;
      brm_pkg::S_SCAN: begin
        if (j_last) state_nxt = brm_pkg::S_OUT;
      end
      brm_pkg::S_OUT: begin
        if (out_acc) state_nxt = is_last ? brm_pkg::S_IDLE : brm_pkg::S_RDA;
      end
      default: state_nxt = brm_pkg::S_IDLE;
    endcase
  end

  // outputs and read address
  always_comb begin
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    rd_addr      = i_r;
    case (state_r)
      brm_pkg::S_IDLE: in_ch.ready  = 1'b1;
      brm_pkg::S_RDA:  rd_addr      = i_r;
      brm_pkg::S_LDA:  rd_addr      = '0;
      brm_pkg::S_SCAN: rd_addr      = AW'(j_r + AW'(1));
      brm_pkg::S_OUT:  out_ch.valid = 1'b1;
      default: ;
    endcase
  end

  assign out_ch.out_position = a_pos_r;
  assign out_ch.out_strand   = a_strand_r;
  assign out_ch.mark_short   = hit_s_r;
  assign out_ch.mark_long    = hit_l_r;
  assign out_ch.overflow     = ovf_r;
  assign out_ch.last         = is_last;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brm_pkg::S_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (hdr_ok) cnt_r <= CW'(cnt_r + CW'(1));
      if (in_acc && in_ch.mode == brm_pkg::MODE_HDR && full) ovf_r <= 1'b1;
      if (in_acc && in_ch.mode == brm_pkg::MODE_GO) begin
        i_r <= '0;
        if (cnt_r == '0) ovf_r <= 1'b0;
      end
      if (state_r == brm_pkg::S_LDA) j_r <= '0;
      if (state_r == brm_pkg::S_SCAN) j_r <= AW'(j_r + AW'(1));
      if (out_acc) begin
        if (is_last) begin
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          i_r <= AW'(i_r + AW'(1));
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.mode == brm_pkg::MODE_GO) begin
      ls_r     <= ls_c;
      ll_r     <= ll_c;
      mask_s_r <= mask_s_c;
      mask_l_r <= mask_l_c;
    end
    if (state_r == brm_pkg::S_LDA) begin
      a_pos_r    <= rd_pos;
      a_strand_r <= rd_strand;
      a_row_r    <= rd_row;
      a_ok_s_r   <= (rd_room >= ls_r);
      a_ok_l_r   <= (rd_room >= ll_r);
      hit_s_r    <= 1'b0;
      hit_l_r    <= 1'b0;
    end
    if (state_r == brm_pkg::S_SCAN) begin
      hit_s_r <= hit_s_r | cmp_s;
      hit_l_r <= hit_l_r | cmp_l;
    end
  end

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken while a result is pending");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_ch.last) |=> (cnt_r == '0 && !ovf_r))
    else $error("bucket not cleared after final result");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(BUCKET_DEPTH))
    else $error("entry count beyond bucket depth");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bucket repeat marker
// Loads buckets of entries (headers and sequence chunks), sends go words and
// checks every result word against an in-bench model of the repeat marking.
// Both channels idle at random; the prefix lengths change between phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH   = 64;
  localparam int MAX_CMP = 100;

  typedef struct packed {
    logic [brm_pkg::MODE_W-1:0]  mode;
    logic [brm_pkg::POS_W-1:0]   pos;
    logic                        strand;
    logic [brm_pkg::LEN_W-1:0]   room;
    logic [brm_pkg::CIDX_W-1:0]  cidx;
    logic [brm_pkg::CHUNK_W-1:0] chunk;
  } load_word_t;

  typedef struct packed {
    logic [brm_pkg::POS_W-1:0] pos;
    logic                      strand;
    logic                      mark_short;
    logic                      mark_long;
    logic                      overflow;
    logic                      last;
  } mark_word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [brm_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [brm_pkg::LEN_W-1:0] cfg_wdata;

  brm_in_if  in_ch ();
  brm_out_if out_ch ();

  bucket_repeat_marker_top #(
    .BUCKET_DEPTH (DEPTH),
    .MAX_COMPARE  (MAX_CMP)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // bucket model
  logic [brm_pkg::POS_W-1:0] bk_pos [DEPTH];
  logic                      bk_strand [DEPTH];
  logic [brm_pkg::LEN_W-1:0] bk_room [DEPTH];
  logic [brm_pkg::ROW_W-1:0] bk_row [DEPTH];
  int                        bk_count = 0;
  logic                      bk_over = 1'b0;
  logic [brm_pkg::LEN_W-1:0] len_short;
  logic [brm_pkg::LEN_W-1:0] len_long;

  load_word_t pending_words[$];
  mark_word_t expected_marks[$];
  load_word_t cur_word;
  int  send_gap;
  int  recv_gap;
  bit  quiet;
  int  n_errors = 0;
  int  n_marks = 0;
  int  n_buckets = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (quiet || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int eff_len(logic [brm_pkg::LEN_W-1:0] len);
    int l;
    l = len;
    if (l > MAX_CMP) l = MAX_CMP;
    if (l > brm_pkg::STORED_BASES) l = brm_pkg::STORED_BASES;
    return l;
  endfunction

  function automatic bit has_repeat(int i, int len);
    logic [brm_pkg::ROW_W-1:0] mask;
    mask = {brm_pkg::ROW_W{1'b1}} >> (brm_pkg::ROW_W - brm_pkg::BASE_W * len);
    if (len == 0) mask = '0;
    if (bk_room[i] < len) return 0;
    for (int j = 0; j < bk_count; j++) begin
      if (j != i && bk_room[j] >= len && ((bk_row[i] ^ bk_row[j]) & mask) == '0)
        return 1;
    end
    return 0;
  endfunction

  // apply one accepted word to the bucket model
  task automatic mark_predict(load_word_t w);
    mark_word_t m;
    int ls, ll;
    case (w.mode)
      brm_pkg::MODE_HDR: begin
        if (bk_count >= DEPTH) begin
          bk_over = 1'b1;
        end else begin
          bk_pos[bk_count]    = w.pos;
          bk_strand[bk_count] = w.strand;
          bk_room[bk_count]   = w.room;
          bk_row[bk_count]    = '0;
          bk_count++;
        end
      end
      brm_pkg::MODE_CHUNK: begin
        if (!bk_over && bk_count != 0 && w.cidx < brm_pkg::N_CHUNK)
          bk_row[bk_count-1][w.cidx*brm_pkg::CHUNK_W +: brm_pkg::CHUNK_W] = w.chunk;
      end
      brm_pkg::MODE_GO: begin
        ls = eff_len(len_short);
        ll = eff_len(len_long);
        for (int i = 0; i < bk_count; i++) begin
          m.pos        = bk_pos[i];
          m.strand     = bk_strand[i];
          m.mark_short = has_repeat(i, ls);
          m.mark_long  = has_repeat(i, ll);
          m.overflow   = bk_over;
          m.last       = (i == bk_count - 1);
          expected_marks.push_back(m);
        end
        bk_count = 0;
        bk_over  = 1'b0;
        n_buckets++;
      end
      default: ;
    endcase
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) mark_predict(cur_word);
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap    <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          cur_word = pending_words.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.mode        <= cur_word.mode;
          in_ch.in_position <= cur_word.pos;
          in_ch.in_strand   <= cur_word.strand;
          in_ch.room        <= cur_word.room;
          in_ch.chunk_index <= cur_word.cidx;
          in_ch.chunk       <= cur_word.chunk;
          send_gap          <= pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    mark_word_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap     <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_marks++;
        if (expected_marks.size() == 0) begin
          $error("result word with nothing expected, position %h", out_ch.out_position);
          n_errors++;
        end else begin
          e = expected_marks.pop_front();
          if (out_ch.out_position !== e.pos) begin
            $error("out_position: expected %h, got %h", e.pos, out_ch.out_position);
            n_errors++;
          end
          if (out_ch.out_strand !== e.strand) begin
            $error("out_strand: expected %b, got %b", e.strand, out_ch.out_strand);
            n_errors++;
          end
          if (out_ch.mark_short !== e.mark_short) begin
            $error("mark_short: expected %b, got %b", e.mark_short, out_ch.mark_short);
            n_errors++;
          end
          if (out_ch.mark_long !== e.mark_long) begin
            $error("mark_long: expected %b, got %b", e.mark_long, out_ch.mark_long);
            n_errors++;
          end
          if (out_ch.overflow !== e.overflow) begin
            $error("overflow: expected %b, got %b", e.overflow, out_ch.overflow);
            n_errors++;
          end
          if (out_ch.last !== e.last) begin
            $error("last: expected %b, got %b", e.last, out_ch.last);
            n_errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap     <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        recv_gap     <= pick_gap();
      end
    end
  end

  function automatic load_word_t hdr_word(logic [brm_pkg::POS_W-1:0] pos, logic strand,
                                          logic [brm_pkg::LEN_W-1:0] room);
    load_word_t w;
    w = '0;
    w.mode = brm_pkg::MODE_HDR; w.pos = pos; w.strand = strand; w.room = room;
    return w;
  endfunction

  function automatic load_word_t chunk_word(logic [brm_pkg::CIDX_W-1:0] idx,
                                            logic [brm_pkg::CHUNK_W-1:0] data);
    load_word_t w;
    w = '0;
    w.mode = brm_pkg::MODE_CHUNK; w.cidx = idx; w.chunk = data;
    return w;
  endfunction

  function automatic load_word_t go_word();
    load_word_t w;
    w = '0;
    w.mode = brm_pkg::MODE_GO;
    return w;
  endfunction

  function automatic logic [brm_pkg::CHUNK_W-1:0] rand_chunk();
    return brm_pkg::CHUNK_W'({$urandom, $urandom});
  endfunction

  function automatic logic [brm_pkg::LEN_W-1:0] rand_room();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return brm_pkg::LEN_W'(100);
    if (r < 8) return brm_pkg::LEN_W'($urandom_range(0, 100));
    return brm_pkg::LEN_W'($urandom_range(0, 127));
  endfunction

  // one bucket: entries drawn from a few seed rows, some with a base changed;
  // only the first n_chk chunks of each entry are candidates for sending
  task automatic queue_bucket(int n_entries, bit sparse, int n_chk);
    logic [brm_pkg::ROW_W-1:0] seeds [4];
    logic [brm_pkg::ROW_W-1:0] row;
    int b;
    for (int s = 0; s < 4; s++)
      for (int c = 0; c < brm_pkg::N_CHUNK; c++)
        seeds[s][c*brm_pkg::CHUNK_W +: brm_pkg::CHUNK_W] = rand_chunk();
    for (int e = 0; e < n_entries; e++) begin
      row = seeds[$urandom_range(0, 3)];
      if ($urandom_range(0, 2) == 0) begin
        b = $urandom_range(0, brm_pkg::STORED_BASES - 1);
        row[b*brm_pkg::BASE_W +: brm_pkg::BASE_W] =
          row[b*brm_pkg::BASE_W +: brm_pkg::BASE_W] ^ brm_pkg::BASE_W'($urandom_range(1, 7));
      end
      pending_words.push_back(hdr_word($urandom, 1'($urandom_range(0, 1)), rand_room()));
      for (int c = 0; c < n_chk; c++) begin
        if (!sparse || $urandom_range(0, 3) != 0)
          pending_words.push_back(chunk_word(brm_pkg::CIDX_W'(c),
                                             row[c*brm_pkg::CHUNK_W +: brm_pkg::CHUNK_W]));
      end
      // occasional noise inside a bucket
      if ($urandom_range(0, 15) == 0)
        pending_words.push_back(chunk_word(brm_pkg::CIDX_W'($urandom_range(5, 7)),
                                           rand_chunk()));
    end
    pending_words.push_back(go_word());
  endtask

  // wait until the bucket is drained and the compare engine is idle
  task automatic drain();
    while (pending_words.size() != 0 || in_ch.valid || expected_marks.size() != 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_lengths(logic [brm_pkg::LEN_W-1:0] s, logic [brm_pkg::LEN_W-1:0] l);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= brm_pkg::REG_SHORT;
    cfg_wdata <= s;
    @(posedge clk);
    len_short = s;
    cfg_addr  <= brm_pkg::REG_LONG;
    cfg_wdata <= l;
    @(posedge clk);
    len_long = l;
    cfg_we <= 1'b0;
  endtask

  initial begin
    load_word_t w;
    int sent;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    len_short = brm_pkg::SHORT_LEN_RST; len_long = brm_pkg::LONG_LEN_RST;
    quiet = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: stray chunk, ignored mode, field extremes, empty go
    pending_words.push_back(chunk_word(3'd0, rand_chunk()));
    w = go_word(); w.mode = brm_pkg::MODE_RSVD; w.pos = '1; w.chunk = '1;
    pending_words.push_back(w);
    pending_words.push_back(go_word());
    pending_words.push_back(hdr_word('0, 1'b0, 7'd127));
    pending_words.push_back(chunk_word(3'd0, '1));
    pending_words.push_back(chunk_word(3'd4, '1));
    pending_words.push_back(chunk_word(3'd7, '1));
    pending_words.push_back(hdr_word('1, 1'b1, 7'd100));
    pending_words.push_back(chunk_word(3'd0, '1));
    pending_words.push_back(chunk_word(3'd4, '1));
    pending_words.push_back(hdr_word(32'h5A5A_A5A5, 1'b0, 7'd0));
    pending_words.push_back(chunk_word(3'd2, '0));
    pending_words.push_back(hdr_word(32'h0000_FFFF, 1'b1, 7'd99));
    pending_words.push_back(chunk_word(3'd0, '1));
    pending_words.push_back(go_word());
    pending_words.push_back(go_word());

    // full bucket with dropped headers and chunks
    set_lengths(7'd1, 7'd127);
    queue_bucket(DEPTH + 3, 1, 1);

    // random buckets under several prefix settings
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      quiet = (ph == 2);
      case (ph)
        0: set_lengths(7'd0, 7'd100);
        1: set_lengths(7'd20, 7'd40);
        2: set_lengths(7'd100, 7'd1);
        3: set_lengths(7'd127, 7'd0);
        default: set_lengths(brm_pkg::LEN_W'($urandom_range(0, 127)),
                             brm_pkg::LEN_W'($urandom_range(0, 127)));
      endcase
      queue_bucket($urandom_range(1, 12), 1'($urandom_range(0, 1)), brm_pkg::N_CHUNK);
      if ($urandom_range(0, 4) == 0) pending_words.push_back(go_word());
    end
    quiet = 0;

    drain();
    repeat (50) @(posedge clk);
    $display("Checked %0d result words over %0d go words, including a full bucket", n_marks,
             n_buckets);
    $display("and prefix lengths from 0 to 127 with random stalls on both channels.");
    if (n_errors == 0 && expected_marks.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
